// ----- hw/rtl/xoshiro_random_generator_core_defines.svh -----
// ---------------------------------------------------------------------------
// xoshiro random generator core: assertion macros
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef XOSHIRO_RANDOM_GENERATOR_CORE_DEFINES_SVH
`define XOSHIRO_RANDOM_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define XRG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define XRG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/xrg_pkg.sv -----
// ---------------------------------------------------------------------------
// xrg_pkg
// Constants shared by the xoshiro256** generator core and its submodules.
// ---------------------------------------------------------------------------
package xrg_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int FRAC_W  = 52;
    localparam int UNIT_W  = 62;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_SEED = 2'd0;
    localparam logic [OP_W-1:0] OP_NEXT = 2'd1;
    localparam logic [OP_W-1:0] OP_JUMP = 2'd2;

    localparam logic [WORD_W-1:0] MIX_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL2  = 64'h94d049bb133111eb;

    localparam logic [10:0] EXP_BIAS_M2 = 11'd1022;

    localparam logic [WORD_W-1:0] JUMP_POLY [4] = '{
        64'h180ec6d33cfd0aba, 64'hd5a61266f0c9392c,
        64'ha9582618e03fc9aa, 64'h39abdc4529b1661c
    };

    typedef logic [WORD_W-1:0] word_t;

endpackage

// ----- hw/rtl/xrg_mul64.sv -----
// ---------------------------------------------------------------------------
// xrg_mul64
// Low 64 bits of a 64x64 product, one 32x32 partial product per cycle.
// ---------------------------------------------------------------------------
module xrg_mul64
    import xrg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t a,
    input  word_t b,
    output logic  done,
    output word_t product
);

    word_t               a_reg, b_reg;
    word_t               acc_reg, acc_next;
    logic [1:0]          step_reg, step_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [HALF_W-1:0]   mx, my;
    word_t               pp;

    // Cross terms only contribute their low half to the low 64 bits.
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                mx = a_reg[HALF_W-1:0];
                my = b_reg[HALF_W-1:0];
            end
            2'd1:
            begin
                mx = a_reg[WORD_W-1:HALF_W];
                my = b_reg[HALF_W-1:0];
            end
            default:
            begin
                mx = a_reg[HALF_W-1:0];
                my = b_reg[WORD_W-1:HALF_W];
            end
        endcase
        pp = WORD_W'(mx) * WORD_W'(my);
    end

    always_comb
    begin
        acc_next  = acc_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (run_reg)
        begin
            if (step_reg == 2'd0)
            begin
                acc_next = pp;
            end
            else
            begin
                acc_next = acc_reg + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
            end
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
        if (start)
        begin
            step_next = 2'd0;
            run_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- hw/rtl/xrg_normalize.sv -----
// ---------------------------------------------------------------------------
// xrg_normalize
// Turns a 52-bit fraction into the double bits of frac/2^52, normalizing
// by a binary search of six shift steps, one per cycle.
// ---------------------------------------------------------------------------
module xrg_normalize
    import xrg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FRAC_W-1:0] frac,
    output logic              done,
    output logic [UNIT_W-1:0] unit_bits
);

    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [5:0]        lz_reg, lz_next;
    logic [2:0]        step_reg, step_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [UNIT_W-1:0] bits_reg, bits_next;
    logic              hit;
    logic [FRAC_W-1:0] shifted;
    logic [5:0]        amt;
    logic [10:0]       expo;

    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                amt = 6'd32;
                hit = (frac_reg[51:20] == '0);
                shifted = {frac_reg[19:0], 32'd0};
            end
            3'd1:
            begin
                amt = 6'd16;
                hit = (frac_reg[51:36] == '0);
                shifted = {frac_reg[35:0], 16'd0};
            end
            3'd2:
            begin
                amt = 6'd8;
                hit = (frac_reg[51:44] == '0);
                shifted = {frac_reg[43:0], 8'd0};
            end
            3'd3:
            begin
                amt = 6'd4;
                hit = (frac_reg[51:48] == '0);
                shifted = {frac_reg[47:0], 4'd0};
            end
            3'd4:
            begin
                amt = 6'd2;
                hit = (frac_reg[51:50] == '0);
                shifted = {frac_reg[49:0], 2'd0};
            end
            default:
            begin
                amt = 6'd1;
                hit = !frac_reg[51];
                shifted = {frac_reg[50:0], 1'b0};
            end
        endcase
    end

    always_comb
    begin
        frac_next = frac_reg;
        lz_next   = lz_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        bits_next = bits_reg;
        expo      = EXP_BIAS_M2 - {5'd0, lz_next};
        if (run_reg)
        begin
            if (hit)
            begin
                frac_next = shifted;
                lz_next   = lz_reg + amt;
            end
            step_next = step_reg + 3'd1;
            expo      = EXP_BIAS_M2 - {5'd0, lz_next};
            if (step_reg == 3'd5)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                // A zero fraction never gets its top bit set and maps to +0.0.
                if (frac_next[FRAC_W-1])
                begin
                    bits_next = {expo[9:0], frac_next[FRAC_W-2:0], 1'b0};
                end
                else
                begin
                    bits_next = '0;
                end
            end
        end
        if (start)
        begin
            frac_next = frac;
            lz_next   = 6'd0;
            step_next = 3'd0;
            run_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg <= frac_next;
        lz_reg   <= lz_next;
        bits_reg <= bits_next;
    end

    assign done      = done_reg;
    assign unit_bits = bits_reg;

endmodule

// ----- hw/rtl/xoshiro_random_generator_core.sv -----
// Work from the accepting edge to the edge that takes the done strobe: next steps the
// state, scrambles the draw and normalizes it; seed runs four splitmix64 steps (each issues
// a multiply and hands its product on to a second, then the strobe); jump runs 256 generator
// steps at one per cycle, then the strobe; an unused code strobes with no other work. One item
// at a time; busy drops in the cycle of the strobe. The receiver cannot stall.
// Reset clears the four state words and idles the sequencer.
// ---------------------------------------------------------------------------
// xoshiro_random_generator_core
// xoshiro256** generator with splitmix64 seeding, 2^128 jump and an exact
// [0,1) double conversion, built around one shared multiplier.
// ---------------------------------------------------------------------------
module xoshiro_random_generator_core
    import xrg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   operation,
    input  logic [WORD_W-1:0] seed_bits,
    output logic              done,
    output logic [WORD_W-1:0] raw_value,
    output logic [UNIT_W-1:0] unit_double_bits
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MIX_A  = 3'd1;
    localparam logic [2:0] S_MIX_AW = 3'd2;
    localparam logic [2:0] S_MIX_BW = 3'd3;
    localparam logic [2:0] S_SCR    = 3'd4;
    localparam logic [2:0] S_NWAIT  = 3'd5;
    localparam logic [2:0] S_JUMP   = 3'd6;

    logic [2:0]  state_reg, state_next;
    word_t       words_reg [4];
    word_t       words_next [4];
    word_t       adv [4];
    word_t       jacc_reg [4];
    word_t       jacc_next [4];
    word_t       mix_in_reg, mix_in_next;
    logic [1:0]  idx_reg, idx_next;
    logic [7:0]  cnt_reg, cnt_next;
    word_t       pre_reg, pre_next;
    word_t       raw_reg, raw_next;
    logic        done_reg, done_next;
    word_t       rawo_reg, rawo_next;
    logic [UNIT_W-1:0] unito_reg, unito_next;

    logic        mul_start, mul_done;
    word_t       mul_a, mul_b, mul_p;
    logic        norm_start, norm_done;
    logic [UNIT_W-1:0] norm_bits;

    word_t       mix_z, mix_out, rot, scr, t17;
    logic        poly_bit;

    xrg_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    xrg_normalize u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (norm_start),
        .frac      (raw_next[WORD_W-1:WORD_W-FRAC_W]),
        .done      (norm_done),
        .unit_bits (norm_bits)
    );

    // One xoshiro256 state step.
    always_comb
    begin
        t17    = {words_reg[1][46:0], 17'd0};
        adv[2] = words_reg[2] ^ words_reg[0];
        adv[3] = words_reg[3] ^ words_reg[1];
        adv[1] = words_reg[1] ^ adv[2];
        adv[0] = words_reg[0] ^ adv[3];
        adv[2] = adv[2] ^ t17;
        adv[3] = {adv[3][18:0], adv[3][63:19]};
    end

    assign mix_z    = mix_in_reg + MIX_GAMMA;
    assign mix_out  = mul_p ^ {31'd0, mul_p[63:31]};
    assign rot      = {pre_reg[56:0], pre_reg[63:57]};
    assign scr      = rot + {rot[60:0], 3'd0};
    assign poly_bit = JUMP_POLY[cnt_reg[7:6]][cnt_reg[5:0]];

    always_comb
    begin
        state_next  = state_reg;
        words_next  = words_reg;
        jacc_next   = jacc_reg;
        mix_in_next = mix_in_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        pre_next    = pre_reg;
        raw_next    = raw_reg;
        done_next   = 1'b0;
        rawo_next   = rawo_reg;
        unito_next  = unito_reg;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        norm_start  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_SEED:
                        begin
                            mix_in_next = seed_bits;
                            idx_next    = 2'd0;
                            state_next  = S_MIX_A;
                        end
                        OP_NEXT:
                        begin
                            pre_next   = words_reg[1] + {words_reg[1][61:0], 2'd0};
                            words_next = adv;
                            state_next = S_SCR;
                        end
                        OP_JUMP:
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                jacc_next[k] = '0;
                            end
                            cnt_next   = 8'd0;
                            state_next = S_JUMP;
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            rawo_next  = '0;
                            unito_next = '0;
                        end
                    endcase
                end
            end
            S_MIX_A:
            begin
                mul_start  = 1'b1;
                mul_a      = mix_z ^ {30'd0, mix_z[63:30]};
                mul_b      = MIX_MUL1;
                state_next = S_MIX_AW;
            end
            S_MIX_AW:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_p ^ {27'd0, mul_p[63:27]};
                    mul_b      = MIX_MUL2;
                    state_next = S_MIX_BW;
                end
            end
            S_MIX_BW:
            begin
                if (mul_done)
                begin
                    words_next[idx_reg] = mix_out;
                    mix_in_next         = mix_out;
                    idx_next            = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        done_next  = 1'b1;
                        rawo_next  = '0;
                        unito_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MIX_A;
                    end
                end
            end
            S_SCR:
            begin
                raw_next   = scr;
                norm_start = 1'b1;
                state_next = S_NWAIT;
            end
            S_NWAIT:
            begin
                if (norm_done)
                begin
                    done_next  = 1'b1;
                    rawo_next  = raw_reg;
                    unito_next = norm_bits;
                    state_next = S_IDLE;
                end
            end
            S_JUMP:
            begin
                if (poly_bit)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        jacc_next[k] = jacc_reg[k] ^ words_reg[k];
                    end
                end
                words_next = adv;
                cnt_next   = cnt_reg + 8'd1;
                if (cnt_reg == 8'hFF)
                begin
                    words_next = jacc_next;
                    done_next  = 1'b1;
                    rawo_next  = '0;
                    unito_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                words_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            words_reg <= words_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jacc_reg   <= jacc_next;
        mix_in_reg <= mix_in_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        pre_reg    <= pre_next;
        raw_reg    <= raw_next;
        rawo_reg   <= rawo_next;
        unito_reg  <= unito_next;
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign raw_value        = rawo_reg;
    assign unit_double_bits = unito_reg;

endmodule

// ----- hw/rtl/xrg_checker.sv -----
// ---------------------------------------------------------------------------
// xrg_checker
// Port-level checks on the generator core's command and result beats.
// ---------------------------------------------------------------------------
`include "xoshiro_random_generator_core_defines.svh"

module xrg_checker
    import xrg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              done,
    input  logic [WORD_W-1:0] raw_value,
    input  logic [UNIT_W-1:0] unit_double_bits
);

    // A result beat only appears once the sequencer has gone idle.
    `XRG_ASSERT_IMP(a_done_not_busy, done, !busy, "result beat while busy")

    // An accepted command either starts work or answers at once.
    `XRG_ASSERT_NXT(a_accept_progress, start && !busy, busy || done, "command dropped")

    // A nonzero unit value needs a nonzero fraction in the raw word.
    `XRG_ASSERT_IMP(a_unit_from_raw, done && (unit_double_bits != '0),
                    raw_value[WORD_W-1:WORD_W-FRAC_W] != '0, "unit value without fraction")

    // The unit value stays below 1.0, so its exponent field is never all ones.
    `XRG_ASSERT_IMP(a_unit_below_one, done, !(&unit_double_bits[UNIT_W-1:FRAC_W]),
                    "unit value out of range")

endmodule

bind xoshiro_random_generator_core xrg_checker u_xrg_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .raw_value        (raw_value),
    .unit_double_bits (unit_double_bits)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: xoshiro_random_generator_core testbench
// Drives seed, next, jump and unused-code commands through the start/busy
// handshake in random bursts. Each accepted command is run through a local
// xoshiro256** model, and every done beat is checked against the oldest
// predicted draw.
// ---------------------------------------------------------------------------
module tb;
    import xrg_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_CMDS    = 750;
    localparam int TAIL_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [OP_W-1:0] op;
        word_t           seed;
        bit              drain;
    } gen_cmd_t;

    typedef struct {
        word_t             raw;
        logic [UNIT_W-1:0] unit;
    } draw_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [OP_W-1:0]   operation = OP_UNUSED;
    word_t             seed_bits = '0;
    logic              busy;
    logic              done;
    word_t             raw_value;
    logic [UNIT_W-1:0] unit_double_bits;

    gen_cmd_t cmd_q [$];
    draw_t    pending_draws [$];
    word_t    gen_words [4];
    int       total_cmds = 0;
    int       n_issued = 0;
    int       n_sent = 0;
    int       n_recv = 0;
    int       err_count = 0;
    int       gap_left = 0;
    int       burst_left = 1;
    int       idle_cycles = 0;

    xoshiro_random_generator_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .seed_bits        (seed_bits),
        .done             (done),
        .raw_value        (raw_value),
        .unit_double_bits (unit_double_bits)
    );

    always #5 clk = ~clk;

    function automatic word_t mix64(word_t v);
        word_t z;
        z = v + MIX_GAMMA;
        z = (z ^ (z >> 30)) * MIX_MUL1;
        z = (z ^ (z >> 27)) * MIX_MUL2;
        return z ^ (z >> 31);
    endfunction

    function automatic word_t rotl64(word_t v, int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // One xoshiro256 step on the local state; returns the scrambled output.
    function automatic word_t step_state();
        word_t out;
        word_t t;
        out = rotl64(gen_words[1] * 64'd5, 7) * 64'd9;
        t = gen_words[1] << 17;
        gen_words[2] ^= gen_words[0];
        gen_words[3] ^= gen_words[1];
        gen_words[1] ^= gen_words[2];
        gen_words[0] ^= gen_words[3];
        gen_words[2] ^= t;
        gen_words[3] = rotl64(gen_words[3], 45);
        return out;
    endfunction

    // Exact double of (raw >> 12) / 2^52, normalized on the leading one.
    function automatic logic [UNIT_W-1:0] to_unit_double(word_t raw);
        logic [FRAC_W-1:0] frac;
        logic [FRAC_W-1:0] mant;
        logic [10:0]       expo;
        word_t             bits;
        int                top;
        frac = raw[WORD_W-1:12];
        if (frac == '0)
            return '0;
        top = FRAC_W - 1;
        while (!frac[top])
            top--;
        expo = 11'(1023 + top - FRAC_W);
        mant = frac << (FRAC_W - top);
        bits = {1'b0, expo, mant};
        return bits[UNIT_W-1:0];
    endfunction

    function automatic void jump_state();
        word_t acc [4];
        for (int k = 0; k < 4; k++)
            acc[k] = '0;
        for (int i = 0; i < 4; i++)
            for (int b = 0; b < WORD_W; b++)
            begin
                if (JUMP_POLY[i][b])
                    for (int k = 0; k < 4; k++)
                        acc[k] ^= gen_words[k];
                void'(step_state());
            end
        for (int k = 0; k < 4; k++)
            gen_words[k] = acc[k];
    endfunction

    function automatic draw_t predict_draw(logic [OP_W-1:0] op, word_t seed);
        draw_t d;
        d.raw = '0;
        d.unit = '0;
        case (op)
            OP_SEED:
            begin
                gen_words[0] = mix64(seed);
                for (int k = 1; k < 4; k++)
                    gen_words[k] = mix64(gen_words[k-1]);
            end
            OP_NEXT:
            begin
                d.raw = step_state();
                d.unit = to_unit_double(d.raw);
            end
            OP_JUMP:
                jump_state();
            default:
                ;
        endcase
        return d;
    endfunction

    task automatic add_cmd(logic [OP_W-1:0] op, word_t seed, bit drain);
        gen_cmd_t c;
        c.op = op;
        c.seed = seed;
        c.drain = drain;
        cmd_q.push_back(c);
    endtask

    // Driver: a command beat is taken at an edge with start high and busy low.
    always @(posedge clk)
    begin : driver
        logic     took;
        gen_cmd_t cmd;
        if (rst_n)
        begin
            took = start && !busy;
            if (took)
            begin
                pending_draws.push_back(predict_draw(operation, seed_bits));
                n_sent <= n_sent + 1;
            end
            if (!start || took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_q.size() > 0 && (!cmd_q[0].drain || n_recv == n_sent + took))
                begin
                    cmd = cmd_q.pop_front();
                    start <= 1'b1;
                    operation <= cmd.op;
                    seed_bits <= cmd.seed;
                    n_issued <= n_issued + 1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: n_sent only counts beats taken at earlier edges, so the front
    // of the queue is always settled when it is compared here.
    always @(posedge clk)
    begin : monitor
        draw_t want;
        if (rst_n && done)
        begin
            if (n_recv >= n_sent)
            begin
                $error("result with no command outstanding: raw_value %h", raw_value);
                err_count++;
            end
            else
            begin
                want = pending_draws.pop_front();
                n_recv <= n_recv + 1;
                if (raw_value !== want.raw)
                begin
                    $error("raw_value mismatch: expected %h, actual %h", want.raw, raw_value);
                    err_count++;
                end
                if (unit_double_bits !== want.unit)
                begin
                    $error("unit_double_bits mismatch: expected %h, actual %h",
                           want.unit, unit_double_bits);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL xoshiro_random_generator_core");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int    r;
        word_t s;
        for (int k = 0; k < 4; k++)
            gen_words[k] = '0;

        // Unseeded state first: draws and a jump must all stay zero; then directed reseeds, draws and jumps.
        add_cmd(OP_NEXT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_cmd(OP_NEXT, '0, 1'b0);
        add_cmd(OP_JUMP, '0, 1'b0);
        add_cmd(OP_UNUSED, 64'h5555_AAAA_5555_AAAA, 1'b0);
        add_cmd(OP_NEXT, '0, 1'b0);
        add_cmd(OP_SEED, '0, 1'b0);
        add_cmd(OP_NEXT, '0, 1'b0);
        add_cmd(OP_NEXT, '0, 1'b0);
        add_cmd(OP_NEXT, '0, 1'b0);
        add_cmd(OP_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_cmd(OP_NEXT, '0, 1'b0);
        add_cmd(OP_SEED, 64'h3FF0_0000_0000_0000, 1'b0);
        add_cmd(OP_NEXT, '0, 1'b0);
        add_cmd(OP_NEXT, '0, 1'b0);
        add_cmd(OP_JUMP, '0, 1'b0);
        add_cmd(OP_NEXT, '0, 1'b0);
        add_cmd(OP_NEXT, '0, 1'b0);
        add_cmd(OP_UNUSED, '0, 1'b0);
        add_cmd(OP_NEXT, '0, 1'b0);
        add_cmd(OP_SEED, 64'h8000_0000_0000_0000, 1'b1);
        add_cmd(OP_NEXT, '0, 1'b0);
        add_cmd(OP_JUMP, '0, 1'b1);
        add_cmd(OP_NEXT, '0, 1'b0);

        // Mostly long runs of draws, with occasional reseeds, jumps and unused codes.
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            r = $urandom_range(0, 99);
            s = {$urandom, $urandom};
            if (r < 3)
                add_cmd(OP_JUMP, s, 1'($urandom_range(0, 1)));
            else if (r < 10)
                add_cmd(OP_SEED, s, 1'b0);
            else if (r < 14)
                add_cmd(OP_UNUSED, s, 1'b0);
            else
                add_cmd(OP_NEXT, s, ($urandom_range(0, 49) == 0));
        end
        total_cmds = cmd_q.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (!(n_issued == total_cmds && !start && n_recv == n_sent))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0 && n_recv == n_sent)
            $display("PASS xoshiro_random_generator_core");
        else
            $display("FAIL xoshiro_random_generator_core");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/xrg_pkg.sv
hw/rtl/xrg_mul64.sv
hw/rtl/xrg_normalize.sv
hw/rtl/xoshiro_random_generator_core.sv
hw/rtl/xrg_checker.sv
test/tb.sv
